FILE: rtl/shell_word_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// Shell word tokenizer assertion macros
// Shared property forms for the port checker of the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef SHELL_WORD_TOKENIZER_TOP_ASSERT_SVH
`define SHELL_WORD_TOKENIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer package
// Character codes, result kinds, lexer modes and shared types.
// ----------------------------------------------------------------------------
package swt_pkg;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Result kinds.
  localparam logic [2:0] KIND_CHAR       = 3'd0;
  localparam logic [2:0] KIND_WORD_END   = 3'd1;
  localparam logic [2:0] KIND_SINGLE_END = 3'd2;
  localparam logic [2:0] KIND_DOUBLE_END = 3'd3;
  localparam logic [2:0] KIND_CMD_END    = 3'd4;
  localparam logic [2:0] KIND_INPUT_END  = 3'd5;
  localparam logic [2:0] KIND_SINGLE_ERR = 3'd6;
  localparam logic [2:0] KIND_DOUBLE_ERR = 3'd7;

  // Lexer modes.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_SINGLE  = 3'd2;
  localparam logic [2:0] MODE_DOUBLE  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  // Results per input transfer and queue sizing.
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Lexer state carried from byte to byte.
  typedef struct packed {
    logic [2:0] mode;
    logic       held_bs;
    logic       held_raw;
  } lex_state_t;

  // All results caused by one input transfer.
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][7:0]   tok_bytes;
    logic [MAX_RES-1:0][2:0]   kinds;
  } res_group_t;

endpackage

FILE: rtl/shell_word_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer top level
// Byte-serial shell-style lexer producing token characters and end markers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) carries one byte per transfer, with
//   in_input_done or a zero byte marking the end of input. The output channel
//   (out_valid, out_stall) carries one result per transfer: a token character
//   or an end marker in out_kind, with out_last set on the final result that
//   an input byte caused. Bytes that cause no result produce no output.
//   An input byte is taken every cycle while the result queue has room. Its
//   results are written into the queue, then loaded into the output group
//   register before they appear. Results leave at one per cycle while
//   out_stall is low, so the output port sets the sustained rate: one byte
//   per cycle while each byte yields at most one result, slower otherwise.
//   A four-entry queue of result groups separates the two sides; while the
//   receiver stalls, the current result holds and input is accepted until the
//   queue fills, after which in_stall rises.
//   Synchronous reset returns the lexer to idle between tokens and empties
//   the queue and the output stage.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_input_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_token_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);
  import swt_pkg::*;

  logic       push;
  res_group_t push_grp;
  logic       q_full;
  logic       pop;
  logic       q_nempty;
  res_group_t head_grp;

  // Lexer step and input handshake.
  swt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_input_done (in_input_done),
    .q_full        (q_full),
    .push          (push),
    .push_grp      (push_grp)
  );

  // Result group queue.
  swt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .nempty   (q_nempty),
    .head_grp (head_grp)
  );

  // Result serializer and output handshake.
  swt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nempty       (q_nempty),
    .head_grp       (head_grp),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_byte (out_token_byte),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/swt_front.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer front end
// Accepts input bytes, steps the lexer state and forms the result group.
// ----------------------------------------------------------------------------
module swt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_input_done,
  input  logic               q_full,
  output logic               push,
  output swt_pkg::res_group_t push_grp
);
  import swt_pkg::*;

  typedef struct packed {
    lex_state_t st;
    res_group_t grp;
  } lex_ctx_t;

  lex_state_t st_r;
  lex_state_t st_nxt;
  lex_ctx_t   ctx;
  logic       accept;

  // Append one result while room remains; extra results are dropped.
  function automatic lex_ctx_t emit(lex_ctx_t x, logic [7:0] b, logic [2:0] k);
    lex_ctx_t r;
    r = x;
    if (x.grp.cnt != 2'd3) begin
      r.grp.tok_bytes[x.grp.cnt] = b;
      r.grp.kinds[x.grp.cnt]     = k;
      r.grp.cnt                  = x.grp.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  // Character seen between tokens.
  function automatic lex_ctx_t idle_char(lex_ctx_t x, logic [7:0] c);
    lex_ctx_t r;
    r = x;
    if (c == CH_DQUOTE) begin
      r.st.mode = MODE_DOUBLE;
    end else if (c == CH_SQUOTE) begin
      r.st.mode = MODE_SINGLE;
    end else if (is_blank(c)) begin
      r = x;
    end else if (c == CH_HASH) begin
      r.st.mode = MODE_COMMENT;
    end else if ((c == CH_NL) || (c == CH_SEMI)) begin
      r = emit(r, CH_NUL, KIND_CMD_END);
    end else begin
      r.st.mode = MODE_WORD;
      if (c == CH_BSLASH) begin
        r.st.held_bs = 1'b1;
      end else begin
        r = emit(r, c, KIND_CHAR);
      end
    end
    return r;
  endfunction

  // One character after line continuations are removed.
  function automatic lex_ctx_t logical_char(lex_ctx_t x, logic [7:0] c);
    lex_ctx_t   r;
    logic [7:0] q;
    logic [2:0] kend;
    logic       skip;
    r    = x;
    q    = (x.st.mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
    kend = (x.st.mode == MODE_SINGLE) ? KIND_SINGLE_END : KIND_DOUBLE_END;
    skip = 1'b0;
    if (x.st.mode == MODE_WORD) begin
      if (x.st.held_bs) begin
        r.st.held_bs = 1'b0;
        r = emit(r, CH_BSLASH, KIND_CHAR);
        r = emit(r, c, KIND_CHAR);
      end else if (c == CH_BSLASH) begin
        r.st.held_bs = 1'b1;
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_SEMI) ||
                   (c == CH_NL) || is_blank(c)) begin
        r = emit(r, CH_NUL, KIND_WORD_END);
        r.st.mode = MODE_IDLE;
        r = idle_char(r, c);
      end else begin
        r = emit(r, c, KIND_CHAR);
      end
    end else if ((x.st.mode == MODE_SINGLE) || (x.st.mode == MODE_DOUBLE)) begin
      if (x.st.held_bs) begin
        r.st.held_bs = 1'b0;
        if (c == q) begin
          r = emit(r, c, KIND_CHAR);
          skip = 1'b1;
        end else begin
          r = emit(r, CH_BSLASH, KIND_CHAR);
        end
      end
      if (!skip) begin
        if (c == q) begin
          r = emit(r, CH_NUL, kend);
          r.st.mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          r.st.held_bs = 1'b1;
        end else begin
          r = emit(r, c, KIND_CHAR);
        end
      end
    end else if (x.st.mode == MODE_COMMENT) begin
      if (c == CH_NL) begin
        r.st.mode = MODE_IDLE;
      end
    end else begin
      r.st.mode    = MODE_IDLE;
      r.st.held_bs = 1'b0;
      r = idle_char(r, c);
    end
    return r;
  endfunction

  // End of input: flush held characters, close the token, reset the state.
  function automatic lex_ctx_t end_of_input(lex_ctx_t x);
    lex_ctx_t r;
    r = x;
    if (x.st.held_raw) begin
      r.st.held_raw = 1'b0;
      r = logical_char(r, CH_BSLASH);
    end
    if (r.st.mode == MODE_WORD) begin
      if (r.st.held_bs) begin
        r = emit(r, CH_BSLASH, KIND_CHAR);
      end
      r = emit(r, CH_NUL, KIND_WORD_END);
      r = emit(r, CH_NUL, KIND_INPUT_END);
    end else if ((r.st.mode == MODE_SINGLE) || (r.st.mode == MODE_DOUBLE)) begin
      if (r.st.held_bs) begin
        r = emit(r, CH_BSLASH, KIND_CHAR);
      end
      r = emit(r, CH_NUL,
               (r.st.mode == MODE_SINGLE) ? KIND_SINGLE_ERR : KIND_DOUBLE_ERR);
    end else begin
      r = emit(r, CH_NUL, KIND_INPUT_END);
    end
    r.st.mode     = MODE_IDLE;
    r.st.held_bs  = 1'b0;
    r.st.held_raw = 1'b0;
    return r;
  endfunction

  // Input transfers are held off only while the result queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // One lexer step for the byte on the input.
  always_comb begin
    ctx     = '0;
    ctx.st  = st_r;
    if (in_input_done || (in_byte == CH_NUL)) begin
      ctx = end_of_input(ctx);
    end else if (st_r.held_raw) begin
      ctx.st.held_raw = 1'b0;
      if (in_byte != CH_NL) begin
        ctx = logical_char(ctx, CH_BSLASH);
        ctx = logical_char(ctx, in_byte);
      end
    end else if (in_byte == CH_BSLASH) begin
      ctx.st.held_raw = 1'b1;
    end else begin
      ctx = logical_char(ctx, in_byte);
    end
  end

  assign st_nxt   = accept ? ctx.st : st_r;
  assign push     = accept && (ctx.grp.cnt != 2'd0);
  assign push_grp = ctx.grp;

  // Lexer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/swt_queue.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer result queue
// Short queue of result groups between the front end and the back end.
// ----------------------------------------------------------------------------
module swt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  swt_pkg::res_group_t push_grp,
  output logic               full,
  input  logic               pop,
  output logic               nempty,
  output swt_pkg::res_group_t head_grp
);
  import swt_pkg::*;

  res_group_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r;
  logic [QUEUE_AW:0]    count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count_r == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nempty   = (count_r != '0);
  assign head_grp = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nempty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

FILE: rtl/swt_back.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer back end
// Takes result groups from the queue and sends one result per unstalled cycle.
// ----------------------------------------------------------------------------
module swt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nempty,
  input  swt_pkg::res_group_t head_grp,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_token_byte,
  output logic [2:0]         out_kind,
  output logic               out_last
);
  import swt_pkg::*;

  res_group_t grp_r;
  logic       grp_v_r;
  logic       grp_v_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       xfer;
  logic       is_last;
  logic       take;

  assign is_last        = (idx_r == grp_r.cnt - 2'd1);
  assign xfer           = grp_v_r && !out_stall;
  assign take           = !grp_v_r || (xfer && is_last);
  assign pop            = take && q_nempty;

  assign out_valid      = grp_v_r;
  assign out_token_byte = grp_r.tok_bytes[idx_r];
  assign out_kind       = grp_r.kinds[idx_r];
  assign out_last       = is_last;

  // Step through the current group, loading the next one after its last result.
  always_comb begin
    grp_v_nxt = grp_v_r;
    idx_nxt   = idx_r;
    if (take) begin
      grp_v_nxt = q_nempty;
      idx_nxt   = 2'd0;
    end else if (xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      grp_v_r <= grp_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Current group payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= head_grp;
    end
  end

endmodule

FILE: rtl/swt_checker.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer port checker
// Checks result ordering and payload rules seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "shell_word_tokenizer_top_assert.svh"

module swt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_token_byte,
  input logic [2:0] out_kind,
  input logic       out_last
);
  import swt_pkg::*;

  // A stalled result keeps its payload.
  `SWT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_token_byte) && $stable(out_kind) && $stable(out_last), "stalled result changed")

  // End markers carry a zero byte.
  `SWT_ASSERT_SAME(a_marker_zero, out_valid && (out_kind != KIND_CHAR), out_token_byte == 8'h00, "end marker with nonzero byte")

  // Only characters and word ends can be followed by more results of the same byte.
  `SWT_ASSERT_SAME(a_marker_last, out_valid && (out_kind != KIND_CHAR) && (out_kind != KIND_WORD_END), out_last, "closing marker not last")

endmodule

bind shell_word_tokenizer_top swt_checker u_swt_checker (.*);

FILE: verif/tb_shell_word_tokenizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shell word tokenizer testbench
// Feeds directed and random character streams through the tokenizer. Every
// accepted byte is run through a behavioral lexer in the bench, and each
// result that leaves the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_shell_word_tokenizer_top;
  import swt_pkg::*;

  // One pending input byte, or a hold-back marker for the sender.
  typedef struct {
    logic [7:0] ch;
    logic       done;
    bit         hold_back;
  } feed_t;

  // One predicted result.
  typedef struct {
    logic [7:0] tok;
    logic [2:0] kind;
    logic       last;
  } lexeme_t;

  localparam int RANDOM_ITEMS = 250;
  localparam int WATCHDOG_NS  = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_input_done = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_token_byte;
  logic [2:0] out_kind;
  logic       out_last;

  feed_t   feed_q[$];
  lexeme_t lexeme_q[$];

  // Lexer state of the bench's own prediction.
  logic [2:0] lx_mode = MODE_IDLE;
  logic       lx_bs = 1'b0;
  logic       lx_raw = 1'b0;
  int         step_n;

  int n_sent = 0;
  int n_results = 0;
  int n_ends = 0;
  int n_errs = 0;
  int cyc = 0;
  logic calm;

  shell_word_tokenizer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_input_done  (in_input_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_byte (out_token_byte),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  // Cycle count; a window of cycles runs with no idling on either side.
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end
  assign calm = (cyc >= 400) && (cyc < 800);

  // ---------------------------------------------------------------------------
  // Lexer prediction
  // ---------------------------------------------------------------------------

  // Appends one result for the current byte, at most three per byte.
  function automatic void put_result(input logic [7:0] ch, input logic [2:0] kind);
    lexeme_t r;
    if (step_n < MAX_RES) begin
      r.tok  = ch;
      r.kind = kind;
      r.last = 1'b0;
      lexeme_q.push_back(r);
      step_n++;
    end
  endfunction

  function automatic bit blank_ch(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  // A character seen while no token is open.
  function automatic void between_tokens(input logic [7:0] c);
    if (c == CH_DQUOTE) begin
      lx_mode = MODE_DOUBLE;
    end else if (c == CH_SQUOTE) begin
      lx_mode = MODE_SINGLE;
    end else if (c == CH_HASH) begin
      lx_mode = MODE_COMMENT;
    end else if (c == CH_NL || c == CH_SEMI) begin
      put_result(CH_NUL, KIND_CMD_END);
    end else if (!blank_ch(c)) begin
      lx_mode = MODE_WORD;
      if (c == CH_BSLASH) lx_bs = 1'b1;
      else put_result(c, KIND_CHAR);
    end
  endfunction

  // A character left after line continuations are removed.
  function automatic void lex_char(input logic [7:0] c);
    logic [7:0] q;
    case (lx_mode)
      MODE_WORD: begin
        if (lx_bs) begin
          lx_bs = 1'b0;
          put_result(CH_BSLASH, KIND_CHAR);
          put_result(c, KIND_CHAR);
        end else if (c == CH_BSLASH) begin
          lx_bs = 1'b1;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SEMI || c == CH_NL ||
                     blank_ch(c)) begin
          put_result(CH_NUL, KIND_WORD_END);
          lx_mode = MODE_IDLE;
          between_tokens(c);
        end else begin
          put_result(c, KIND_CHAR);
        end
      end
      MODE_SINGLE, MODE_DOUBLE: begin
        q = (lx_mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (lx_bs && c == q) begin
          // Backslash before the closing quote gives the quote itself.
          lx_bs = 1'b0;
          put_result(c, KIND_CHAR);
        end else begin
          if (lx_bs) begin
            lx_bs = 1'b0;
            put_result(CH_BSLASH, KIND_CHAR);
          end
          if (c == q) begin
            put_result(CH_NUL, (lx_mode == MODE_SINGLE) ? KIND_SINGLE_END : KIND_DOUBLE_END);
            lx_mode = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            lx_bs = 1'b1;
          end else begin
            put_result(c, KIND_CHAR);
          end
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) lx_mode = MODE_IDLE;
      end
      default: begin
        lx_mode = MODE_IDLE;
        lx_bs = 1'b0;
        between_tokens(c);
      end
    endcase
  endfunction

  // End of input: flush whatever is open, then return to idle.
  function automatic void lex_finish();
    if (lx_raw) begin
      lx_raw = 1'b0;
      lex_char(CH_BSLASH);
    end
    case (lx_mode)
      MODE_WORD: begin
        if (lx_bs) put_result(CH_BSLASH, KIND_CHAR);
        put_result(CH_NUL, KIND_WORD_END);
        put_result(CH_NUL, KIND_INPUT_END);
      end
      MODE_SINGLE, MODE_DOUBLE: begin
        if (lx_bs) put_result(CH_BSLASH, KIND_CHAR);
        put_result(CH_NUL, (lx_mode == MODE_SINGLE) ? KIND_SINGLE_ERR : KIND_DOUBLE_ERR);
      end
      default: begin
        put_result(CH_NUL, KIND_INPUT_END);
      end
    endcase
    lx_mode = MODE_IDLE;
    lx_bs = 1'b0;
    lx_raw = 1'b0;
  endfunction

  // Predicts the results of one accepted input byte.
  function automatic void predict_byte(input logic [7:0] b, input logic done);
    step_n = 0;
    if (done || b == CH_NUL) begin
      n_ends++;
      lex_finish();
    end else if (lx_raw) begin
      // A raw backslash followed by newline is a line continuation.
      lx_raw = 1'b0;
      if (b != CH_NL) begin
        lex_char(CH_BSLASH);
        lex_char(b);
      end
    end else if (b == CH_BSLASH) begin
      lx_raw = 1'b1;
    end else begin
      lex_char(b);
    end
    if (step_n > 0) lexeme_q[lexeme_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_ch(input logic [7:0] c);
    feed_t f;
    f.ch = c;
    f.done = 1'b0;
    f.hold_back = 1'b0;
    feed_q.push_back(f);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  // End of input, either by the done flag with any byte or by a zero byte.
  task automatic push_end(input bit by_flag);
    feed_t f;
    f.ch = by_flag ? 8'($urandom_range(0, 255)) : CH_NUL;
    f.done = by_flag;
    f.hold_back = 1'b0;
    feed_q.push_back(f);
  endtask

  // The sender waits here until every predicted result has arrived.
  task automatic push_hold();
    feed_t f;
    f.ch = CH_NUL;
    f.done = 1'b0;
    f.hold_back = 1'b1;
    feed_q.push_back(f);
  endtask

  function automatic logic [7:0] any_ch_but(input logic [7:0] skip);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == skip) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] word_ch();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SEMI || c == CH_BSLASH)
      c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  task automatic queue_word();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        push_ch(CH_BSLASH);
        push_ch(8'($urandom_range(1, 255)));
      end else begin
        push_ch(word_ch());
      end
    end
  endtask

  // Quoted string with random content; now and then left open.
  task automatic queue_quoted(input logic [7:0] q);
    int len;
    int r;
    len = $urandom_range(0, 5);
    push_ch(q);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(9);
      if (r == 0) begin
        push_ch(CH_BSLASH);
        push_ch(q);
      end else if (r == 1) begin
        push_ch(CH_BSLASH);
        push_ch(any_ch_but(q));
      end else begin
        push_ch(any_ch_but(q));
      end
    end
    if ($urandom_range(9) != 0) push_ch(q);
  endtask

  task automatic queue_separator();
    case ($urandom_range(5))
      0: push_ch(CH_SPACE);
      1: push_ch(CH_TAB);
      2: push_ch(CH_VT);
      3: push_ch(CH_FF);
      4: push_ch(CH_CR);
      default: begin
        push_ch(CH_BSLASH);
        push_ch(CH_NL);
      end
    endcase
  endtask

  // One command line of random tokens, sometimes cut off by end of input.
  task automatic queue_line();
    int ntok;
    int r;
    ntok = $urandom_range(1, 4);
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(19);
      if (r < 10) begin
        queue_word();
      end else if (r < 13) begin
        queue_quoted(CH_SQUOTE);
      end else if (r < 16) begin
        queue_quoted(CH_DQUOTE);
      end else if (r == 16) begin
        push_ch(CH_HASH);
        repeat ($urandom_range(0, 6)) push_ch(any_ch_but(CH_NL));
        push_ch(CH_NL);
      end else begin
        repeat ($urandom_range(1, 3)) push_ch(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(3) != 0) queue_separator();
    end
    if ($urandom_range(5) == 0) push_end(1'($urandom_range(1)));
    else push_ch(($urandom_range(1) != 0) ? CH_NL : CH_SEMI);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending bytes and predicts each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    feed_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(in_byte, in_input_done);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && feed_q[0].hold_back) begin
          if (lexeme_q.size() == 0) void'(feed_q.pop_front());
          in_valid <= 1'b0;
        end else if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          nx = feed_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nx.ch;
          in_input_done <= nx.done;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer and stalls at random
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (n_errs < 40) $display("MISMATCH @%0t: %s", $time, msg);
    n_errs++;
  endtask

  always @(posedge clk) begin
    lexeme_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lexeme_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    out_kind, out_token_byte));
        end else begin
          want = lexeme_q.pop_front();
          n_results++;
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          if (out_token_byte !== want.tok)
            report_mismatch($sformatf("token byte %02h, expected %02h",
                                      out_token_byte, want.tok));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    bit mid_hold;
    int target;
    mid_hold = 1'b0;

    // Closed single quote, then a comment whose newline ends no command.
    push_ch(CH_SQUOTE); push_text("x"); push_ch(CH_SQUOTE);
    push_ch(CH_HASH); push_ch(CH_NL);
    // Top byte opens a word, an escaped backslash keeps both, a tab ends it.
    push_ch(8'hFF); push_ch(CH_BSLASH); push_ch(CH_BSLASH); push_ch(CH_TAB);
    // Double quote with a low byte and an escaped quote, closed, command end.
    push_ch(CH_DQUOTE); push_ch(8'h01); push_ch(CH_BSLASH); push_ch(CH_DQUOTE);
    push_ch(CH_DQUOTE); push_ch(CH_NL);
    // Open single quote with a trailing backslash, ended by a zero byte.
    push_ch(CH_SQUOTE); push_ch(CH_BSLASH); push_end(1'b0);
    // Word with a trailing backslash, ended by the done flag.
    push_text("w"); push_ch(CH_BSLASH); push_end(1'b1);
    // Other blanks, a line continuation, a semicolon, an open double quote.
    push_ch(CH_VT); push_ch(CH_FF); push_ch(CH_BSLASH); push_ch(CH_NL); push_ch(CH_CR);
    push_ch(CH_SEMI); push_ch(CH_DQUOTE); push_end(1'b1);
    push_hold();

    // Random command lines, with one more drain in the middle.
    target = feed_q.size() + RANDOM_ITEMS;
    while (feed_q.size() < target) begin
      queue_line();
      if (!mid_hold && feed_q.size() > target / 2) begin
        push_hold();
        mid_hold = 1'b1;
      end
    end
    push_end(1'($urandom_range(1)));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge, where the queues and valid are settled.
    while (feed_q.size() != 0 || in_valid || lexeme_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes including %0d ends of input; checked %0d results.",
             n_sent, n_ends, n_results);
    $display("Covered words, both quote styles, escapes, comments and continuations.");
    if (n_errs == 0 && lexeme_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #WATCHDOG_NS;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/swt_pkg.sv
rtl/swt_front.sv
rtl/swt_queue.sv
rtl/swt_back.sv
rtl/shell_word_tokenizer_top.sv
rtl/swt_checker.sv
verif/tb_shell_word_tokenizer_top.sv
